// ===== sv/led_blink_pattern_sequencer_core_defines.svh =====
// ----------------------------------------------------------------------------
// LED blink sequencer assertion macros
// Shared macros for the concurrent assertions of the blink sequencer checker.
// ----------------------------------------------------------------------------
`ifndef LED_BLINK_PATTERN_SEQUENCER_CORE_DEFINES_SVH
`define LED_BLINK_PATTERN_SEQUENCER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LBPS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("blink sequencer check failed");

// The consequent must hold in the cycle after the antecedent.
`define LBPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("blink sequencer check failed");

`endif

// ===== sv/lbps_pkg.sv =====
// ----------------------------------------------------------------------------
// LED blink sequencer package
// Word types, register indexes and reset constants shared by the design.
// ----------------------------------------------------------------------------
package lbps_pkg;

    localparam int unsigned TimeWidth = 16;
    localparam int unsigned CfgIndexWidth = 2;

    localparam logic [CfgIndexWidth-1:0] CFG_IDLE_COLOR    = 2'd0;
    localparam logic [CfgIndexWidth-1:0] CFG_IDLE_ON_TIME  = 2'd1;
    localparam logic [CfgIndexWidth-1:0] CFG_IDLE_OFF_TIME = 2'd2;

    localparam logic                        COLOR_WHITE        = 1'b0;
    localparam logic                        COLOR_RED          = 1'b1;
    localparam logic                        REQ_TICK           = 1'b0;
    localparam logic                        REQ_PATTERN        = 1'b1;
    localparam logic                        RESET_IDLE_COLOR   = COLOR_WHITE;
    localparam logic [TimeWidth-1:0]        RESET_IDLE_ON      = 16'd100;
    localparam logic [TimeWidth-1:0]        RESET_IDLE_OFF     = 16'd900;
    localparam logic signed [TimeWidth-1:0] REPEAT_FOREVER     = -16'sd1;

    typedef struct packed {
        logic                        req_type;
        logic                        pattern_color;
        logic [TimeWidth-1:0]        on_time;
        logic [TimeWidth-1:0]        off_time;
        logic signed [TimeWidth-1:0] repeat_count;
    } lbps_item_t;

    typedef struct packed {
        logic white_led;
        logic red_led;
    } lbps_led_t;

    typedef struct packed {
        logic                 color;
        logic [TimeWidth-1:0] on_time;
        logic [TimeWidth-1:0] off_time;
    } lbps_idle_t;

endpackage

// ===== sv/lbps_engine.sv =====
// ----------------------------------------------------------------------------
// LED blink sequencer pattern engine
// Holds the current pattern and its phase timing, and computes the LED drive
// that follows each accepted word.
// ----------------------------------------------------------------------------
module lbps_engine (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  lbps_pkg::lbps_item_t item,
    input  lbps_pkg::lbps_idle_t idle,
    output lbps_pkg::lbps_led_t  led_next
);
    import lbps_pkg::*;

    logic                        in_off_phase_reg;
    logic                        in_off_phase_next;
    logic [TimeWidth-1:0]        elapsed_ms_reg;
    logic [TimeWidth-1:0]        elapsed_ms_next;
    logic signed [TimeWidth-1:0] repeats_left_reg;
    logic signed [TimeWidth-1:0] repeats_left_next;
    logic                        color_reg;
    logic                        color_next;
    logic [TimeWidth-1:0]        on_time_reg;
    logic [TimeWidth-1:0]        on_time_next;
    logic [TimeWidth-1:0]        off_time_reg;
    logic [TimeWidth-1:0]        off_time_next;

    logic [TimeWidth-1:0]        phase_len;
    logic [TimeWidth-1:0]        elapsed_inc;
    logic signed [TimeWidth-1:0] repeats_dec;

    assign phase_len   = in_off_phase_reg ? off_time_reg : on_time_reg;
    assign elapsed_inc = elapsed_ms_reg + TimeWidth'(1);
    assign repeats_dec = repeats_left_reg - TimeWidth'(1);

    always_comb
    begin
        in_off_phase_next = in_off_phase_reg;
        elapsed_ms_next   = elapsed_ms_reg;
        repeats_left_next = repeats_left_reg;
        color_next        = color_reg;
        on_time_next      = on_time_reg;
        off_time_next     = off_time_reg;
        if (item.req_type == REQ_PATTERN)
        begin
            color_next        = item.pattern_color;
            on_time_next      = item.on_time;
            off_time_next     = item.off_time;
            repeats_left_next = item.repeat_count;
            in_off_phase_next = 1'b0;
            elapsed_ms_next   = '0;
        end
        else if ((phase_len == '0) || (elapsed_inc >= phase_len))
        begin
            // A zero length phase behaves as a one tick phase.
            elapsed_ms_next = '0;
            if (!in_off_phase_reg)
            begin
                in_off_phase_next = 1'b1;
            end
            else
            begin
                in_off_phase_next = 1'b0;
                if (repeats_left_reg > 0)
                begin
                    repeats_left_next = repeats_dec;
                    if (repeats_dec == '0)
                    begin
                        color_next        = idle.color;
                        on_time_next      = idle.on_time;
                        off_time_next     = idle.off_time;
                        repeats_left_next = REPEAT_FOREVER;
                    end
                end
            end
        end
        else
        begin
            elapsed_ms_next = elapsed_inc;
        end
    end

    assign led_next.white_led = !in_off_phase_next && (color_next == COLOR_WHITE);
    assign led_next.red_led   = !in_off_phase_next && (color_next == COLOR_RED);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_off_phase_reg <= 1'b0;
            elapsed_ms_reg   <= '0;
            repeats_left_reg <= REPEAT_FOREVER;
            color_reg        <= RESET_IDLE_COLOR;
            on_time_reg      <= RESET_IDLE_ON;
            off_time_reg     <= RESET_IDLE_OFF;
        end
        else if (step)
        begin
            in_off_phase_reg <= in_off_phase_next;
            elapsed_ms_reg   <= elapsed_ms_next;
            repeats_left_reg <= repeats_left_next;
            color_reg        <= color_next;
            on_time_reg      <= on_time_next;
            off_time_reg     <= off_time_next;
        end
    end

endmodule

// ===== sv/led_blink_pattern_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// LED blink pattern sequencer core
// Two-colour status LED blinker driven by millisecond ticks and pattern words.
// ----------------------------------------------------------------------------
// Each word on the item channel is either a one millisecond tick or a new
// blink pattern; every accepted word yields exactly one word on the led
// channel, holding the white and red LED drive after that word.
// led_valid rises in the cycle after acceptance; one word can be accepted
// every cycle while led_ready holds, set by the single engine update stage.
// The led word sits in an output register; item_ready stays high while that
// register is empty or being emptied, so a stalled receiver stops the input
// only while its word is still waiting.
// The config channel writes the idle colour, on time and off time used when a
// finite pattern ends; writes to unknown indexes are ignored.
// Reset loads the idle heartbeat of 100 on and 900 off in white; both
// channels are held not ready until the first cycle after reset.
// ----------------------------------------------------------------------------
module led_blink_pattern_sequencer_core (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   item_valid,
    output logic                                   item_ready,
    input  lbps_pkg::lbps_item_t                   item_data,
    output logic                                   led_valid,
    input  logic                                   led_ready,
    output lbps_pkg::lbps_led_t                    led_data,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [lbps_pkg::CfgIndexWidth-1:0]     cfg_index,
    input  logic [lbps_pkg::TimeWidth-1:0]         cfg_data
);
    import lbps_pkg::*;

    logic        run_reg;
    logic        led_valid_reg;
    logic        led_valid_next;
    lbps_led_t   led_data_reg;
    lbps_led_t   led_next;
    lbps_idle_t  idle_reg;
    lbps_idle_t  idle_next;
    logic        step;

    assign item_ready = run_reg && (!led_valid_reg || led_ready);
    assign cfg_ready  = run_reg;
    assign step       = item_valid && item_ready;
    assign led_valid  = led_valid_reg;
    assign led_data   = led_data_reg;

    always_comb
    begin
        idle_next = idle_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_IDLE_COLOR:    idle_next.color    = cfg_data[0];
                CFG_IDLE_ON_TIME:  idle_next.on_time  = cfg_data;
                CFG_IDLE_OFF_TIME: idle_next.off_time = cfg_data;
                default:           idle_next = idle_reg;
            endcase
        end
    end

    always_comb
    begin
        led_valid_next = led_valid_reg;
        if (step)
        begin
            led_valid_next = 1'b1;
        end
        else if (led_ready)
        begin
            led_valid_next = 1'b0;
        end
    end

    lbps_engine u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .item     (item_data),
        .idle     (idle_reg),
        .led_next (led_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg           <= 1'b0;
            led_valid_reg     <= 1'b0;
            idle_reg.color    <= RESET_IDLE_COLOR;
            idle_reg.on_time  <= RESET_IDLE_ON;
            idle_reg.off_time <= RESET_IDLE_OFF;
        end
        else
        begin
            run_reg       <= 1'b1;
            led_valid_reg <= led_valid_next;
            idle_reg      <= idle_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            led_data_reg <= led_next;
        end
    end

endmodule

// ===== sv/lbps_checker.sv =====
// ----------------------------------------------------------------------------
// LED blink sequencer port checker
// Concurrent checks on the top level ports, attached by a bind statement.
// ----------------------------------------------------------------------------
`include "led_blink_pattern_sequencer_core_defines.svh"

module lbps_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 item_valid,
    input logic                 item_ready,
    input lbps_pkg::lbps_item_t item_data,
    input logic                 led_valid,
    input logic                 led_ready,
    input lbps_pkg::lbps_led_t  led_data
);
    import lbps_pkg::*;

    logic      pattern_taken;
    lbps_led_t pattern_drive;

    assign pattern_taken           = item_valid && item_ready && (item_data.req_type == REQ_PATTERN);
    assign pattern_drive.white_led = (item_data.pattern_color == COLOR_WHITE);
    assign pattern_drive.red_led   = (item_data.pattern_color == COLOR_RED);

    `LBPS_ASSERT_NOW(a_one_colour, clk, rst_n, led_valid, !(led_data.white_led && led_data.red_led))

    `LBPS_ASSERT_NEXT(a_led_held, clk, rst_n, led_valid && !led_ready, led_valid && $stable(led_data))

    `LBPS_ASSERT_NEXT(a_word_out, clk, rst_n, item_valid && item_ready, led_valid)

    `LBPS_ASSERT_NEXT(a_drained, clk, rst_n, item_ready && !item_valid && led_valid && led_ready, !led_valid)

    `LBPS_ASSERT_NEXT(a_pattern_lit, clk, rst_n, pattern_taken, led_data == $past(pattern_drive))

endmodule

bind led_blink_pattern_sequencer_core lbps_checker u_lbps_checker (.*);
